FILE: hw/rtl/gbn_pkg.sv
// shared constants and the cell control type for the greedy box nms block
// no dependencies
package gbn_pkg;

	localparam int DEF_MAX_BOXES       = 64;
	localparam int DEF_COORD_BITS      = 16;
	localparam int DEF_COORD_FRAC_BITS = 4;

	localparam int FIELD_W    = 16;
	localparam int THR_W      = 17;
	localparam int THR_FRAC_W = 16;
	localparam int KEPT_W     = 6;
	localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic load; // sorted insert of the broadcast box
		logic pop;  // shift towards the head
		logic app;  // append broadcast box at the tail
	} cell_ctl_t;

endpackage

FILE: hw/rtl/gbn_cell.sv
// one cell of the box chain: holds a box, its score and a valid bit
// depends on gbn_pkg
module gbn_cell #(
	parameter int BOX_W   = 90,
	parameter int SCORE_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gbn_pkg::cell_ctl_t   ctl,
	input  logic [BOX_W-1:0]     new_box,
	input  logic [SCORE_W-1:0]   new_score,
	input  logic                 prev_beat,
	input  logic                 prev_valid,
	input  logic [BOX_W-1:0]     prev_box,
	input  logic [SCORE_W-1:0]   prev_score,
	input  logic                 next_valid,
	input  logic [BOX_W-1:0]     next_box,
	input  logic [SCORE_W-1:0]   next_score,
	output logic                 beat,
	output logic                 valid,
	output logic [BOX_W-1:0]     box,
	output logic [SCORE_W-1:0]   score
);
	import gbn_pkg::*;

	logic               valid_q;
	logic [BOX_W-1:0]   box_q;
	logic [SCORE_W-1:0] score_q;

	// newcomer ranks ahead of a stored box only on a strictly higher score, and always ahead of an empty cell
	assign beat  = !valid_q || (new_score > score_q);
	assign valid = valid_q;
	assign box   = box_q;
	assign score = score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			if (prev_beat) begin
				valid_q <= prev_valid;
			end else if (beat) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (ctl.app) begin
			if (!valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (prev_beat) begin
				box_q   <= prev_box;
				score_q <= prev_score;
			end else if (beat) begin
				box_q   <= new_box;
				score_q <= new_score;
			end
		end else if (ctl.pop) begin
			box_q   <= next_box;
			score_q <= next_score;
		end else if (ctl.app) begin
			if (!valid_q && prev_valid) begin
				box_q   <= new_box;
				score_q <= new_score;
			end
		end
	end

endmodule

FILE: hw/rtl/gbn_iou.sv
// pipelined overlap test: iou(a, b) >= threshold by cross-multiplication
// depends on gbn_pkg
module gbn_iou #(
	parameter int COORD_BITS      = 16,
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   go,
	input  logic [4*COORD_BITS+2*(COORD_BITS+1)-1:0] a_box,
	input  logic [4*COORD_BITS+2*(COORD_BITS+1)-1:0] b_box,
	input  logic [gbn_pkg::THR_W-1:0]              thr,
	output logic                                   done,
	output logic                                   hit
);
	import gbn_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int SPAN_W = CB + 1;
	localparam int AREA_W = 2 * SPAN_W;
	localparam int SUM_W  = AREA_W + 1;
	localparam int PROD_W = SUM_W + THR_W;
	localparam logic [SPAN_W-1:0] ONE = SPAN_W'(1) << COORD_FRAC_BITS;

	logic [CB-1:0]     xx1, yy1, xx2, yy2;
	logic [SPAN_W-1:0] ex, ey, sx, sy;
	logic [SPAN_W-1:0] sx_s1, sy_s1;
	logic [SUM_W-1:0]  sum_s1, sum_s2;
	logic [AREA_W-1:0] inter_s2, inter_s3;
	logic [SUM_W-1:0]  uni_s3;
	logic [PROD_W-1:0] rhs_s4, lhs_s4;
	logic              zero_s4;
	logic [3:0]        vld_q;
	logic              hit_q;
	logic              done_q;

	always_comb begin
		xx1 = (a_box[CB-1:0] > b_box[CB-1:0]) ? a_box[CB-1:0] : b_box[CB-1:0];
		yy1 = (a_box[2*CB-1:CB] > b_box[2*CB-1:CB]) ? a_box[2*CB-1:CB] : b_box[2*CB-1:CB];
		xx2 = (a_box[3*CB-1:2*CB] < b_box[3*CB-1:2*CB]) ?
			a_box[3*CB-1:2*CB] : b_box[3*CB-1:2*CB];
		yy2 = (a_box[4*CB-1:3*CB] < b_box[4*CB-1:3*CB]) ?
			a_box[4*CB-1:3*CB] : b_box[4*CB-1:3*CB];
		ex  = {1'b0, xx2} + ONE;
		ey  = {1'b0, yy2} + ONE;
		sx  = (ex > {1'b0, xx1}) ? ex - {1'b0, xx1} : '0;
		sy  = (ey > {1'b0, yy1}) ? ey - {1'b0, yy1} : '0;
	end

	always_ff @(posedge clk) begin
		sx_s1    <= sx;
		sy_s1    <= sy;
		sum_s1   <= {1'b0, a_box[4*CB+AREA_W-1:4*CB]} + {1'b0, b_box[4*CB+AREA_W-1:4*CB]};
		inter_s2 <= sx_s1 * sy_s1;
		sum_s2   <= sum_s1;
		uni_s3   <= sum_s2 - {1'b0, inter_s2};
		inter_s3 <= inter_s2;
		rhs_s4   <= uni_s3 * thr;
		lhs_s4   <= PROD_W'({inter_s3, {THR_FRAC_W{1'b0}}});
		zero_s4  <= (uni_s3 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[2:0], go};
			hit_q <= !zero_s4 && (lhs_s4 >= rhs_s4);
		end
	end

	// result register follows the fourth stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[3];
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

endmodule

FILE: hw/rtl/greedy_box_nms_top.sv
// greedy non-maximum suppression over a chain of box cells
// sequence: boxes load one per cycle; after the last box a drain state, then each kept box
// takes a head pop, an empty test and an emit, plus per remaining box tested against it a
// test issue with a pop, a wait on the five-stage overlap unit, then an append if not suppressed
// a new set is accepted only after every kept box of the previous set has been emitted
// reset: async active-low, chain emptied, threshold back to 45875, no set in progress
// depends on gbn_pkg, gbn_cell, gbn_iou
module greedy_box_nms_top #(
	parameter int MAX_BOXES       = gbn_pkg::DEF_MAX_BOXES,
	parameter int COORD_BITS      = gbn_pkg::DEF_COORD_BITS,
	parameter int COORD_FRAC_BITS = gbn_pkg::DEF_COORD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// slave side: box_left, box_top, box_right, box_bottom, box_score (16 bits each)
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [79:0]               s_tdata,
	input  logic                      s_tlast,   // last_box
	// master side: kept_index [5:0], zero pad [7:6]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,
	output logic                      m_tlast,   // last_kept
	output logic                      m_tuser,   // overflow
	// threshold register, unsigned q1.16
	input  logic                      cfg_we,
	input  logic [gbn_pkg::THR_W-1:0] cfg_wdata
);
	import gbn_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int SPAN_W  = CB + 1;
	localparam int AREA_W  = 2 * SPAN_W;
	localparam int GEOM_W  = 4 * CB + AREA_W;
	localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int BOX_W   = GEOM_W + IDX_W;
	localparam int CNT_W   = $clog2(MAX_BOXES + 1);
	localparam int SCORE_W = FIELD_W;
	localparam logic [SPAN_W-1:0] ONE = SPAN_W'(1) << COORD_FRAC_BITS;
	localparam logic [CNT_W-1:0]  CAP = CNT_W'(MAX_BOXES);

	typedef enum logic [2:0] {
		ST_LOAD, ST_DRAIN, ST_HEAD, ST_TEST, ST_WAIT, ST_EMIT
	} state_t;

	state_t             state_q;
	logic [THR_W-1:0]   thr_q;
	logic [CNT_W-1:0]   cnt_q;     // boxes stored in this set
	logic [CNT_W-1:0]   live_q;    // boxes still in the chain
	logic [CNT_W-1:0]   rem_q;     // boxes left to test this pass
	logic               ovf_q;
	logic [BOX_W-1:0]   ref_q;     // box kept in the current pass
	logic [BOX_W-1:0]   cand_q;    // box under test
	logic [SCORE_W-1:0] cand_score_q;
	logic               go_q;

	// input stage: coordinates and spans held for the area multiply
	logic               vld_s1;
	logic [4*CB-1:0]    crd_s1;
	logic [SPAN_W-1:0]  sx_s1, sy_s1;
	logic [SCORE_W-1:0] score_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [CB-1:0]      in_l, in_t, in_r, in_b;
	logic [SPAN_W-1:0]  ex, ey, sx, sy;
	logic [AREA_W-1:0]  area_s1;
	logic               in_acc;

	// output register
	logic               m_vld_q;
	logic [KEPT_W-1:0]  kept_q;
	logic               last_q;
	logic               ovf_out_q;

	// chain wiring
	cell_ctl_t          ctl;
	logic [BOX_W-1:0]   bcast_box;
	logic [SCORE_W-1:0] bcast_score;
	logic               c_beat  [MAX_BOXES];
	logic               c_valid [MAX_BOXES];
	logic [BOX_W-1:0]   c_box   [MAX_BOXES];
	logic [SCORE_W-1:0] c_score [MAX_BOXES];

	logic               iou_done, iou_hit;

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;

	// coordinates reduced to the configured width
	always_comb begin
		in_l = CB'(s_tdata[15:0]);
		in_t = CB'(s_tdata[31:16]);
		in_r = CB'(s_tdata[47:32]);
		in_b = CB'(s_tdata[63:48]);
		ex   = {1'b0, in_r} + ONE;
		ey   = {1'b0, in_b} + ONE;
		// inverted box gives a zero span
		sx   = (ex > {1'b0, in_l}) ? ex - {1'b0, in_l} : '0;
		sy   = (ey > {1'b0, in_t}) ? ey - {1'b0, in_t} : '0;
	end

	assign area_s1 = sx_s1 * sy_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			crd_s1   <= {in_b, in_r, in_t, in_l};
			sx_s1    <= sx;
			sy_s1    <= sy;
			score_s1 <= s_tdata[79:64];
			idx_s1   <= IDX_W'(cnt_q);
		end
	end

	// broadcast bus: freshly loaded box, or a surviving candidate sent back to the tail
	always_comb begin
		ctl.load    = vld_s1;
		ctl.pop     = 1'b0;
		ctl.app     = (state_q == ST_WAIT) && iou_done && !iou_hit;
		bcast_box   = cand_q;
		bcast_score = cand_score_q;
		if (vld_s1) begin
			bcast_box   = {idx_s1, area_s1, crd_s1};
			bcast_score = score_s1;
		end
		if (state_q == ST_HEAD || (state_q == ST_TEST && rem_q != '0)) begin
			ctl.pop = 1'b1;
		end
	end

	// the chain: head at cell 0, kept in rank order
	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		logic               p_beat, p_valid, n_valid;
		logic [BOX_W-1:0]   p_box, n_box;
		logic [SCORE_W-1:0] p_score, n_score;

		if (i == 0) begin : g_head
			assign p_beat  = 1'b0;
			assign p_valid = 1'b1;
			assign p_box   = bcast_box;
			assign p_score = bcast_score;
		end else begin : g_body
			assign p_beat  = c_beat[i-1];
			assign p_valid = c_valid[i-1];
			assign p_box   = c_box[i-1];
			assign p_score = c_score[i-1];
		end

		if (i == MAX_BOXES - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_box   = bcast_box;
			assign n_score = bcast_score;
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_box   = c_box[i+1];
			assign n_score = c_score[i+1];
		end

		gbn_cell #(
			.BOX_W   (BOX_W),
			.SCORE_W (SCORE_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_box    (bcast_box),
			.new_score  (bcast_score),
			.prev_beat  (p_beat),
			.prev_valid (p_valid),
			.prev_box   (p_box),
			.prev_score (p_score),
			.next_valid (n_valid),
			.next_box   (n_box),
			.next_score (n_score),
			.beat       (c_beat[i]),
			.valid      (c_valid[i]),
			.box        (c_box[i]),
			.score      (c_score[i])
		);
	end

	gbn_iou #(
		.COORD_BITS      (COORD_BITS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.a_box  (ref_q[GEOM_W-1:0]),
		.b_box  (cand_q[GEOM_W-1:0]),
		.thr    (thr_q),
		.done   (iou_done),
		.hit    (iou_hit)
	);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// head pop captures reference and candidate boxes
	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD) begin
			ref_q <= c_box[0];
		end
		if (state_q == ST_TEST && rem_q != '0) begin
			cand_q       <= c_box[0];
			cand_score_q <= c_score[0];
		end
	end

	// sequencer: load, then per kept box a head pop and a pass over the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			live_q    <= '0;
			rem_q     <= '0;
			ovf_q     <= 1'b0;
			vld_s1    <= 1'b0;
			go_q      <= 1'b0;
			m_vld_q   <= 1'b0;
			kept_q    <= '0;
			last_q    <= 1'b0;
			ovf_out_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			vld_s1 <= 1'b0;
			if (m_vld_q && m_tready) begin
				m_vld_q <= 1'b0;
			end
			if (vld_s1) begin
				live_q <= live_q + 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q != CAP) begin
							vld_s1 <= 1'b1;
							cnt_q  <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					// best remaining box is kept
					live_q  <= live_q - 1'b1;
					rem_q   <= live_q - 1'b1;
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (rem_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						live_q  <= live_q - 1'b1;
						rem_q   <= rem_q - 1'b1;
						go_q    <= 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (iou_done) begin
						if (!iou_hit) begin
							live_q <= live_q + 1'b1;
						end
						state_q <= ST_TEST;
					end
				end
				ST_EMIT: begin
					if (!m_vld_q || m_tready) begin
						m_vld_q   <= 1'b1;
						kept_q    <= KEPT_W'(ref_q[BOX_W-1:GEOM_W]);
						last_q    <= (live_q == '0);
						ovf_out_q <= ovf_q;
						if (live_q == '0) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {{(8 - KEPT_W){1'b0}}, kept_q};
	assign m_tlast  = last_q;
	assign m_tuser  = ovf_out_q;

endmodule

FILE: dv/greedy_box_nms_top_tb.sv
// self-checking testbench for greedy_box_nms_top: streams box sets, predicts kept indices
// depends on gbn_pkg and the greedy_box_nms_top rtl
module greedy_box_nms_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gbn_pkg::*;

	localparam int NBOX      = DEF_MAX_BOXES;
	localparam int ONE_PX    = 1 << DEF_COORD_FRAC_BITS;
	localparam int CYC_LIMIT = 2_000_000;

	typedef struct packed {
		logic [15:0] score;
		logic [15:0] bottom;
		logic [15:0] right;
		logic [15:0] top;
		logic [15:0] left;
	} box_t;

	typedef struct {
		logic [KEPT_W-1:0] idx;
		logic              last;
		logic              ovf;
	} kept_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [79:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast, m_tuser;
	logic [7:0] m_tdata;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	greedy_box_nms_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state: current set and the threshold copy
	box_t        set_boxes[NBOX];
	int          set_count;
	bit          set_ovf;
	logic [THR_W-1:0] thr_model;
	kept_t       kept_q[$];

	int  errors, n_boxes, n_kept, n_sets;
	longint cycles;
	bit  rx_hold;   // long receiver hold-off
	bit  tx_calm;   // stretch with no idling on either side

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// inclusive extent, zero when empty
	function automatic longint unsigned extent(longint unsigned lo, longint unsigned hi);
		return (hi + ONE_PX > lo) ? hi + ONE_PX - lo : 0;
	endfunction

	function automatic longint unsigned box_area(box_t b);
		return extent(b.left, b.right) * extent(b.top, b.bottom);
	endfunction

	// iou >= threshold, by cross-multiplication at full width
	function automatic bit iou_hits(box_t a, box_t b, logic [THR_W-1:0] thr);
		longint unsigned x1, y1, x2, y2, inter, uni;
		logic [127:0] lhs, rhs;
		x1 = (a.left > b.left) ? a.left : b.left;
		y1 = (a.top > b.top) ? a.top : b.top;
		x2 = (a.right < b.right) ? a.right : b.right;
		y2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
		inter = extent(x1, x2) * extent(y1, y2);
		uni = box_area(a) + box_area(b) - inter;
		if (uni == 0) return 1'b0;
		lhs = {64'd0, inter} << THR_FRAC_W;
		rhs = {64'd0, uni} * {111'd0, thr};
		return lhs >= rhs;
	endfunction

	// rank the set, suppress greedily, queue the kept indices
	task automatic predict_kept();
		int order[NBOX];
		bit gone[NBOX];
		int i, j, cur, first_new;
		first_new = kept_q.size();
		for (i = 0; i < set_count; i++) begin
			gone[i] = 1'b0;
			cur = i;
			j = i;
			while (j > 0 && set_boxes[order[j-1]].score < set_boxes[cur].score) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = cur;
		end
		for (i = 0; i < set_count; i++) begin
			kept_t k;
			if (gone[order[i]]) continue;
			k.idx = order[i][KEPT_W-1:0];
			k.last = 1'b0;
			k.ovf = set_ovf;
			kept_q = {kept_q, k};
			for (j = i + 1; j < set_count; j++)
				if (!gone[order[j]] && iou_hits(set_boxes[order[i]], set_boxes[order[j]],
						thr_model))
					gone[order[j]] = 1'b1;
		end
		if (kept_q.size() > first_new) kept_q[$].last = 1'b1;
		set_count = 0;
		set_ovf = 1'b0;
		n_sets++;
	endtask

	// one box transaction on the slave side, with random idling
	task automatic send_box(box_t b, bit last);
		while (!tx_calm && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (set_count < NBOX) begin
			set_boxes[set_count] = b;
			set_count++;
		end else
			set_ovf = 1'b1;
		n_boxes++;
		if (last) predict_kept();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (kept_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// register write while idle
	task automatic write_thr(logic [THR_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_model = v;
	endtask

	function automatic box_t rand_box(int span_max);
		box_t b;
		b.left   = 16'($urandom_range(16'hFFFF));
		b.top    = 16'($urandom_range(16'hFFFF));
		b.right  = 16'(b.left + $urandom_range(span_max));
		b.bottom = 16'(b.top + $urandom_range(span_max));
		b.score  = 16'($urandom_range(16'hFFFF));
		return b;
	endfunction

	// jittered copy of a box so that overlaps happen
	function automatic box_t near_box(box_t b);
		box_t c;
		c = b;
		c.left   = 16'(b.left + $urandom_range(64) - 32);
		c.top    = 16'(b.top + $urandom_range(64) - 32);
		c.right  = 16'(b.right + $urandom_range(64) - 32);
		c.bottom = 16'(b.bottom + $urandom_range(64) - 32);
		c.score  = ($urandom_range(3) == 0) ? b.score : 16'($urandom_range(16'hFFFF));
		return c;
	endfunction

	// clustered set of n boxes
	task automatic send_cluster_set(int n);
		box_t anchor, b;
		anchor = rand_box(400);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: b = rand_box(16'hFFFF);
				1, 2: b = rand_box(300);
				default: b = near_box(anchor);
			endcase
			if ($urandom_range(5) == 0) anchor = b;
			send_box(b, i == n - 1);
		end
	endtask

	// edges, inverted boxes, equal scores, zero areas
	task automatic test_directed();
		box_t b;
		b = '{score: 16'hFFFF, bottom: 16'hFFFF, right: 16'hFFFF, top: 16'h0, left: 16'h0};
		send_box(b, 1'b0);
		send_box(b, 1'b0);                                     // identical, tie on score
		b = '{score: 16'h0, bottom: 16'h0, right: 16'h0, top: 16'hFFFF, left: 16'hFFFF};
		send_box(b, 1'b0);                                     // inverted
		send_box(b, 1'b0);                                     // two zero-area boxes
		b = '{score: 16'h8000, bottom: 16'h00F0, right: 16'h00F0, top: 16'h0010,
			left: 16'h0010};
		send_box(b, 1'b0);
		b.left = 16'h0050;
		send_box(b, 1'b0);                                     // partial overlap
		b = '{score: 16'h5555, bottom: 16'hAAAA, right: 16'h5555, top: 16'h5555,
			left: 16'hAAAA};
		send_box(b, 1'b1);                                     // inverted in x only
		b = '{score: 16'h1234, bottom: 16'h10, right: 16'h10, top: 16'h10, left: 16'h10};
		send_box(b, 1'b1);                                     // single-box set
	endtask

	// capacity: a full set plus extras, last one ends it
	task automatic test_overflow();
		for (int i = 0; i < NBOX + 3; i++)
			send_box(rand_box(800), i == NBOX + 2);
	endtask

	// threshold extremes and midpoints
	task automatic test_thresholds();
		write_thr('0);
		send_cluster_set(6);
		write_thr(17'h10000);
		send_cluster_set(6);
		write_thr(17'h1FFFF);
		send_cluster_set(6);
		write_thr(17'h08000);
		send_cluster_set(6);
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 60) begin
			int n;
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 16) : $urandom_range(8, 1);
			if ($urandom_range(7) == 0) write_thr(THR_W'($urandom_range(17'h1FFFF)));
			send_cluster_set(n);
			sent += n;
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		rx_hold = 1'b1;
		tx_calm = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				rx_hold = 1'b0;
			end
			begin
				for (int s = 0; s < 4; s++) send_cluster_set(12);
				s_tvalid <= 1'b0;
			end
		join
		tx_calm = 1'b0;
		drain();   // sender pauses until every result is in
	endtask

	// result checker and receiver readiness
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (kept_q.size() == 0) begin
				$error("unexpected kept index %0d", m_tdata[KEPT_W-1:0]);
				errors++;
			end else begin
				kept_t e;
				e = kept_q.pop_front();
				if (m_tdata[KEPT_W-1:0] !== e.idx) begin
					$error("kept_index exp %0d got %0d", e.idx, m_tdata[KEPT_W-1:0]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_kept exp %0b got %0b", e.last, m_tlast);
					errors++;
				end
				if (m_tuser !== e.ovf) begin
					$error("overflow exp %0b got %0b", e.ovf, m_tuser);
					errors++;
				end
				n_kept++;
			end
		end
		m_tready <= !rx_hold && (tx_calm || $urandom_range(99) >= 26);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("[greedy_box_nms_top] ERROR");
			$finish;
		end
	end

	initial begin
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		m_tready = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		errors = 0; n_boxes = 0; n_kept = 0; n_sets = 0; cycles = 0;
		set_count = 0; set_ovf = 1'b0; thr_model = THR_RESET;
		rx_hold = 1'b0; tx_calm = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_thresholds();
		write_thr(THR_RESET);
		test_backpressure();
		test_random();
		drain();
		if (kept_q.size() != 0) begin
			$error("%0d kept indices never arrived", kept_q.size());
			errors++;
		end
		$display("covered %0d boxes in %0d sets, %0d kept indices checked",
			n_boxes, n_sets, n_kept);
		if (errors == 0)
			$display("[greedy_box_nms_top] OK");
		else
			$display("[greedy_box_nms_top] ERROR");
		$finish;
	end
endmodule
